>>> src/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types and constants of the polynomial easing curve unit.
// ----------------------------------------------------------------------------
package pec_pkg;

    localparam int FRAC_BITS = 15;
    localparam int VW        = FRAC_BITS + 3;
    localparam int PW        = 2 * VW;
    localparam int OUT_W     = 17;

    localparam logic [VW-1:0] ONE_Q  = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF_Q = VW'(1) << (FRAC_BITS - 1);

    localparam longint C1_L   = ((longint'(170158) << FRAC_BITS) + 50000) / 100000;
    localparam longint C3_L   = ((longint'(270158) << FRAC_BITS) + 50000) / 100000;
    localparam longint C2_L   = ((longint'(259490950) << FRAC_BITS) + 50000000) / 100000000;
    localparam longint C2P1_L = ((longint'(359490950) << FRAC_BITS) + 50000000) / 100000000;

    localparam logic [VW-1:0] C1_Q   = VW'(C1_L);
    localparam logic [VW-1:0] C3_Q   = VW'(C3_L);
    localparam logic [VW-1:0] C2_Q   = VW'(C2_L);
    localparam logic [VW-1:0] C2P1_Q = VW'(C2P1_L);

    typedef enum logic [2:0] {
        KIND_QUAD   = 3'd0,
        KIND_CUBIC  = 3'd1,
        KIND_QUART  = 3'd2,
        KIND_QUINT  = 3'd3,
        KIND_BACK   = 3'd4,
        KIND_BOUNCE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        DIR_IN    = 2'd0,
        DIR_OUT   = 2'd1,
        DIR_INOUT = 2'd2,
        DIR_SPARE = 2'd3
    } dir_t;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_DIR  = 1'b1;

    // rounded product a*b / 2^k, ties up
    function automatic logic [VW-1:0] rmul(input logic [VW-1:0] a,
                                           input logic [VW-1:0] b,
                                           input logic          extra);
        logic [PW-1:0] p;
        logic [PW-1:0] s;
        p = a * b;
        s = extra ? (p >> FRAC_BITS) : (p >> (FRAC_BITS - 1));
        return VW'((s + PW'(1)) >> 1);
    endfunction

endpackage

>>> src/polynomial_easing_curve_unit_top.sv
// ----------------------------------------------------------------------------
// polynomial_easing_curve_unit_top
// Fixed-point easing curves (power, back, bounce) over a stream of times.
// ----------------------------------------------------------------------------
// s_axis carries Q1.15 time beats, m_axis the eased value in signed Q2.15.
// curve_kind (index 0) and curve_direction (index 1) are written through
// cfg_we/cfg_addr/cfg_wdata; the user must write them only while no beat
// is in flight, as the block does not enforce it. The datapath is a
// six-stage pipeline, one rounded multiply per stage in stages 1 to 4 for
// the power chain; a beat is accepted every cycle unless a full pipe stalls.
// When m_axis_tready is low the output beat holds and the stages behind it
// close up; once all six stages are full s_axis_tready drops, so no beat is
// dropped or repeated, and a bubble in the pipe is filled even while the
// output stalls.
// Reset clears the configuration to quad / ease in and empties the pipe.
// ----------------------------------------------------------------------------
module polynomial_easing_curve_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // time_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // eased_value, zero fill
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    localparam int VW = pec_pkg::VW;
    localparam int NS = 6;

    typedef struct packed {
        logic [2:0]    kind;
        logic [1:0]    dir;
        logic          half;
        logic          sub;
        logic [VW-1:0] t;
        logic [VW-1:0] x;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] c;
        logic [VW-1:0] d;
    } ctx_t;

    logic [2:0] kind_reg;
    logic [1:0] dir_reg;
    logic [NS-1:0] vld_reg;
    ctx_t st_reg [NS];
    logic [NS-1:0] adv;
    ctx_t s0_next, s1_next, s2_next, s3_next, s4_next, s5_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 3'd0;
            dir_reg  <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pec_pkg::CFG_KIND: kind_reg <= cfg_wdata;
                pec_pkg::CFG_DIR:  dir_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        adv[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--) adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign s_axis_tready = adv[0];

    // stage 0: clamp and choose argument
    always_comb begin
        logic [VW-1:0] t;
        logic [1:0] d;
        s0_next = '0;
        t = (s_axis_tdata > 16'(pec_pkg::ONE_Q)) ? pec_pkg::ONE_Q : VW'(s_axis_tdata);
        d = (dir_reg == pec_pkg::DIR_SPARE) ? pec_pkg::DIR_INOUT : dir_reg;
        s0_next.kind = kind_reg;
        s0_next.dir  = d;
        s0_next.t    = t;
        s0_next.half = t >= pec_pkg::HALF_Q;
        if (kind_reg == pec_pkg::KIND_BOUNCE) begin
            unique case (d)
                pec_pkg::DIR_IN:  s0_next.x = pec_pkg::ONE_Q - t;
                pec_pkg::DIR_OUT: s0_next.x = t;
                default: s0_next.x = s0_next.half ? (t << 1) - pec_pkg::ONE_Q
                                                  : pec_pkg::ONE_Q - (t << 1);
            endcase
        end else begin
            unique case (d)
                pec_pkg::DIR_IN:  s0_next.x = t;
                pec_pkg::DIR_OUT: s0_next.x = pec_pkg::ONE_Q - t;
                default: s0_next.x = s0_next.half ? (pec_pkg::ONE_Q << 1) - (t << 1)
                                                  : (t << 1);
            endcase
        end
        s0_next.sub = (d == pec_pkg::DIR_OUT) || (d != pec_pkg::DIR_IN && s0_next.half);
    end

    // stage 1: square (power/back) or bounce distance
    always_comb begin
        logic [VW+3:0] e;
        logic [VW+3:0] e22;
        logic [VW+3:0] one;
        logic [VW+3:0] dd;
        s1_next = st_reg[0];
        dd = '0;
        one = (VW+4)'(pec_pkg::ONE_Q);
        e = (VW+4)'(st_reg[0].x) * 4'd11;
        e22 = (VW+4)'(st_reg[0].x) * 5'd22;
        if (st_reg[0].kind == pec_pkg::KIND_BOUNCE) begin
            priority if (e < one * 4) begin
                dd = e; s1_next.b = VW'(0);
            end else if (e < one * 8) begin
                dd = (e >= one * 6) ? (VW+4)'(e - one * 6) : (VW+4)'(one * 6 - e);
                s1_next.b = VW'(1);
            end else if (e < one * 10) begin
                dd = (e >= one * 9) ? (VW+4)'(e - one * 9) : (VW+4)'(one * 9 - e);
                s1_next.b = VW'(2);
            end else begin
                dd = (e22 >= one * 21) ? (VW+4)'(e22 - one * 21) : (VW+4)'(one * 21 - e22);
                s1_next.b = VW'(3);
            end
            s1_next.a = VW'(dd);
        end else begin
            s1_next.a = pec_pkg::rmul(st_reg[0].x, st_reg[0].x,
                   st_reg[0].kind == pec_pkg::KIND_QUAD && st_reg[0].dir == pec_pkg::DIR_INOUT);
        end
    end

    // stage 2: cube (power and back) / back in-out linear term / bounce square
    always_comb begin
        logic io;
        logic [2*VW+7:0] sq;
        int sh;
        io = st_reg[1].dir == pec_pkg::DIR_INOUT;
        s2_next = st_reg[1];
        sq = '0;
        sh = 0;
        if (st_reg[1].kind == pec_pkg::KIND_BOUNCE) begin
            sq = (2*VW+8)'(st_reg[1].a) * (2*VW+8)'(st_reg[1].a);
            sh = pec_pkg::FRAC_BITS + ((st_reg[1].b == VW'(3)) ? 6 : 4) + (io ? 1 : 0);
            s2_next.a = VW'((((sq >> (sh - 1)) + 1) >> 1));
        end else if (st_reg[1].kind == pec_pkg::KIND_BACK) begin
            s2_next.c = io ? pec_pkg::rmul(pec_pkg::C2P1_Q, st_reg[1].x, 1'b0)
                           : pec_pkg::rmul(st_reg[1].a, st_reg[1].x, 1'b0);
        end else begin
            s2_next.c = pec_pkg::rmul(st_reg[1].a, st_reg[1].x,
                   st_reg[1].kind == pec_pkg::KIND_CUBIC && io);
        end
    end

    // stage 3: fourth power / back terms
    always_comb begin
        logic io;
        io = st_reg[2].dir == pec_pkg::DIR_INOUT;
        s3_next = st_reg[2];
        if (st_reg[2].kind == pec_pkg::KIND_BACK) begin
            if (io) begin
                s3_next.d = (st_reg[2].c >= pec_pkg::C2_Q) ? st_reg[2].c - pec_pkg::C2_Q
                                                           : pec_pkg::C2_Q - st_reg[2].c;
                s3_next.b = VW'(st_reg[2].c < pec_pkg::C2_Q);
            end else begin
                s3_next.c = pec_pkg::rmul(pec_pkg::C3_Q, st_reg[2].c, 1'b0);
                s3_next.d = pec_pkg::rmul(pec_pkg::C1_Q, st_reg[2].a, 1'b0);
            end
        end else if (st_reg[2].kind != pec_pkg::KIND_BOUNCE) begin
            s3_next.d = pec_pkg::rmul(st_reg[2].c, st_reg[2].x,
                   st_reg[2].kind == pec_pkg::KIND_QUART && io);
        end
    end

    // stage 4: fifth power / back product
    always_comb begin
        logic io;
        io = st_reg[3].dir == pec_pkg::DIR_INOUT;
        s4_next = st_reg[3];
        if (st_reg[3].kind == pec_pkg::KIND_BACK && io) begin
            s4_next.d = pec_pkg::rmul(st_reg[3].a, st_reg[3].d, 1'b1);
        end else if (st_reg[3].kind == pec_pkg::KIND_QUINT) begin
            s4_next.d = pec_pkg::rmul(st_reg[3].d, st_reg[3].x, io);
        end
    end

    // stage 5: combine and saturate
    always_comb begin
        logic signed [VW+1:0] p;
        logic signed [VW+1:0] r;
        logic signed [VW+1:0] one;
        logic signed [VW+1:0] half;
        logic [2:0] k;
        s5_next = st_reg[4];
        one  = (VW+2)'(pec_pkg::ONE_Q);
        half = (VW+2)'(pec_pkg::HALF_Q);
        k = st_reg[4].kind;
        unique case (k)
            pec_pkg::KIND_QUAD:  p = (VW+2)'(st_reg[4].a);
            pec_pkg::KIND_CUBIC: p = (VW+2)'(st_reg[4].c);
            pec_pkg::KIND_QUART,
            pec_pkg::KIND_QUINT: p = (VW+2)'(st_reg[4].d);
            pec_pkg::KIND_BACK: begin
                if (st_reg[4].dir == pec_pkg::DIR_INOUT)
                    p = st_reg[4].b[0] ? -(VW+2)'(st_reg[4].d) : (VW+2)'(st_reg[4].d);
                else
                    p = (VW+2)'(st_reg[4].c) - (VW+2)'(st_reg[4].d);
            end
            pec_pkg::KIND_BOUNCE: begin
                p = (VW+2)'(st_reg[4].a);
                unique case (st_reg[4].b[1:0])
                    2'd0: ;
                    2'd1: p = p + (VW+2)'((one * 3) >>>
                              (st_reg[4].dir == pec_pkg::DIR_INOUT ? 3 : 2));
                    2'd2: p = p + (VW+2)'((one * 15) >>>
                              (st_reg[4].dir == pec_pkg::DIR_INOUT ? 5 : 4));
                    default: p = p + (VW+2)'((one * 63) >>>
                                 (st_reg[4].dir == pec_pkg::DIR_INOUT ? 7 : 6));
                endcase
            end
            default: p = (VW+2)'(st_reg[4].t);
        endcase
        if (k == pec_pkg::KIND_BOUNCE) begin
            unique case (st_reg[4].dir)
                pec_pkg::DIR_IN:  r = one - p;
                pec_pkg::DIR_OUT: r = p;
                default: r = st_reg[4].half ? half + p : half - p;
            endcase
        end else if (k > pec_pkg::KIND_BOUNCE) begin
            r = p;
        end else begin
            r = st_reg[4].sub ? one - p : p;
        end
        if (r > (VW+2)'(65535)) r = (VW+2)'(65535);
        if (r < -(VW+2)'(65536)) r = -(VW+2)'(65536);
        s5_next.x = VW'(r);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NS; i++) if (adv[i]) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) st_reg[0] <= s0_next;
        if (adv[1]) st_reg[1] <= s1_next;
        if (adv[2]) st_reg[2] <= s2_next;
        if (adv[3]) st_reg[3] <= s3_next;
        if (adv[4]) st_reg[4] <= s4_next;
        if (adv[5]) st_reg[5] <= s5_next;
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {7'd0, st_reg[NS-1].x[pec_pkg::OUT_W-1:0]};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NS-1] |-> s_axis_tready)
        else $error("pipe blocked with empty output stage");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat lost at entry");

endmodule
